// ----- sv/pcm_sample_playback_mixer_core_defines.svh -----
// assertion macros used by the checker of the pcm playback mixer
// depends on: nothing; expects i_clk and i_rst_n in the using scope
`ifndef PCM_SAMPLE_PLAYBACK_MIXER_CORE_DEFINES_SVH
`define PCM_SAMPLE_PLAYBACK_MIXER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCMMIX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PCMMIX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pcmmix_pkg.sv -----
// package of the pcm playback mixer: types, codes and fixed widths
// depends on: nothing
`timescale 1ns / 1ps

package pcmmix_pkg;

    localparam int DEF_CHANNELS      = 8;
    localparam int DEF_RAM_ADDR_BITS = 16;
    localparam int FRAC_BITS         = 11;
    localparam int ADDR_W            = 16;
    localparam int POS_W             = ADDR_W + FRAC_BITS;
    localparam int RATE_W            = 24;
    localparam int SUM_W             = 18;
    localparam logic [7:0] MARKER    = 8'hFF;
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd48260;

    typedef enum logic [1:0] {
        FN_REG  = 2'd0,
        FN_RAM  = 2'd1,
        FN_TICK = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        RG_ENV      = 4'd0,
        RG_PAN      = 4'd1,
        RG_STEP_LO  = 4'd2,
        RG_STEP_HI  = 4'd3,
        RG_LOOP_LO  = 4'd4,
        RG_LOOP_HI  = 4'd5,
        RG_START    = 4'd6,
        RG_CONTROL  = 4'd7,
        RG_CHAN_ON  = 4'd8
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHAN,
        ST_BYTE,
        ST_LOOP,
        ST_GAIN,
        ST_MIX,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_FINAL,
        ST_DONE
    } t_state;

endpackage

// ----- sv/pcmmix_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on: nothing
`timescale 1ns / 1ps

module pcmmix_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pcm_sample_playback_mixer_core.sv -----
// top level of the pcm playback mixer: request decode, channel registers, tick sequencer
// depends on: pcmmix_pkg, pcmmix_ram
`timescale 1ns / 1ps

// Eight-channel PCM wavetable playback mixer. A request is taken when start is high
// and busy is low: a register write or a sample ram byte write completes in the
// accept cycle (busy stays low), a tick walks the enabled channels one at a time
// through one ram read port and one shared add/compare path, then shows left_sum,
// right_sum and sounding for exactly one cycle with o_valid. The receiver cannot
// stall, so sample the result in that cycle. A tick with master off goes straight to
// the result; otherwise every channel is visited in turn, a disabled one in the channel
// state only and an enabled one through the channel, byte, gain, mix, scan and final
// states, with the loop state added when the byte at its position is a loop marker (the
// channel then ends there, silent, when the byte at the loop address is a marker too),
// plus a read of every byte skipped over by the channel's step, since each skipped byte
// is read and checked for a loop marker through the single ram read port. After reset
// the sample ram is swept to zero, one byte per cycle, with busy high; the rate_scale
// register at byte 0 can be written over the apb port at any time the block is idle.
module pcm_sample_playback_mixer_core #(
    parameter int CHANNELS      = pcmmix_pkg::DEF_CHANNELS,
    parameter int RAM_ADDR_BITS = pcmmix_pkg::DEF_RAM_ADDR_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic [3:0]                    i_reg_index,
    input  logic [7:0]                    i_value,
    input  logic [11:0]                   i_ram_offset,
    // result channel
    output logic                          o_valid,
    output logic signed [pcmmix_pkg::SUM_W-1:0] o_left_sum,
    output logic signed [pcmmix_pkg::SUM_W-1:0] o_right_sum,
    output logic                          o_sounding,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import pcmmix_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [RAM_ADDR_BITS-1:0] LAST_ADDR = '1;

    // channel registers
    logic [7:0]        r_env   [CHANNELS];
    logic [7:0]        r_pan   [CHANNELS];
    logic [15:0]       r_base  [CHANNELS];
    logic [ADDR_W-1:0] r_loop  [CHANNELS];
    logic [7:0]        r_page  [CHANNELS];
    logic [POS_W-1:0]  r_pos   [CHANNELS];
    logic [CHANNELS-1:0] r_on;

    // global registers
    logic [2:0]        r_sel;
    logic [3:0]        r_bank;
    logic              r_master;
    logic [RATE_W-1:0] r_rate;

    // sequencer registers
    t_state            r_state, n_state;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [ADDR_W-1:0] r_a, n_a;
    logic [ADDR_W:0]   r_k, n_k;
    logic [7:0]        r_b, n_b;
    logic [6:0]        r_gl, n_gl, r_gr, n_gr;
    logic [POS_W-1:0]  r_step, n_step;
    logic [SUM_W-1:0]  r_acc_l, n_acc_l, r_acc_r, n_acc_r;
    logic [RAM_ADDR_BITS-1:0] r_clr, n_clr;
    logic              r_valid, n_valid;
    logic              r_sounding, n_sounding;
    logic [SUM_W-1:0]  r_out_l, n_out_l, r_out_r, n_out_r;

    // position write from the sequencer
    logic              pos_we;
    logic [POS_W-1:0]  pos_val;

    // ram ports
    logic                     ram_we;
    logic [RAM_ADDR_BITS-1:0] ram_waddr, rd_addr;
    logic [7:0]               ram_wdata, rdata;

    logic accept, cfg_wr, sel_ok;
    logic [CH_W-1:0] sel_idx;
    logic [39:0] step_prod;
    logic [11:0] prod_l, prod_r;
    logic [13:0] mix_l, mix_r;
    logic [POS_W-1:0] new_pos, loop_pos;
    logic [15:0] bank_addr;

    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign busy    = (r_state != ST_IDLE);
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : {8'd0, r_rate};
    assign sel_ok  = ({1'b0, r_sel} < 4'(CHANNELS));
    assign sel_idx = CH_W'(r_sel);

    assign o_valid     = r_valid;
    assign o_left_sum  = r_out_l;
    assign o_right_sum = r_out_r;
    assign o_sounding  = r_sounding;

    assign bank_addr = {r_bank, i_ram_offset};

    // ram write: clearing sweep, else byte writes at accept
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = accept && (i_func == FN_RAM);
            ram_waddr = bank_addr[RAM_ADDR_BITS-1:0];
            ram_wdata = i_value;
        end
    end

    pcmmix_ram #(
        .WIDTH (8),
        .DEPTH (2 ** RAM_ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // shared arithmetic of the current channel
    assign step_prod = {24'd0, r_base[r_ch]} * {16'd0, r_rate};
    assign prod_l    = r_env[r_ch] * r_pan[r_ch][3:0];
    assign prod_r    = r_env[r_ch] * r_pan[r_ch][7:4];
    assign mix_l     = r_b[6:0] * r_gl;
    assign mix_r     = r_b[6:0] * r_gr;
    assign new_pos   = r_pos[r_ch] + r_step;
    assign loop_pos  = {r_loop[r_ch], {FRAC_BITS{1'b0}}};

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_a        = r_a;
        n_k        = r_k;
        n_b        = r_b;
        n_gl       = r_gl;
        n_gr       = r_gr;
        n_step     = r_step;
        n_acc_l    = r_acc_l;
        n_acc_r    = r_acc_r;
        n_clr      = r_clr;
        n_valid    = 1'b0;
        n_sounding = r_sounding;
        n_out_l    = r_out_l;
        n_out_r    = r_out_r;
        pos_we     = 1'b0;
        pos_val    = loop_pos;
        rd_addr    = r_a[RAM_ADDR_BITS-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_func == FN_TICK)) begin
                    n_acc_l    = '0;
                    n_acc_r    = '0;
                    n_ch       = '0;
                    n_sounding = r_master;
                    n_state    = r_master ? ST_CHAN : ST_DONE;
                end
            end
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHAN: begin
                // fetch byte at the current position and latch this channel's step
                n_a     = r_pos[r_ch][POS_W-1:FRAC_BITS];
                rd_addr = n_a[RAM_ADDR_BITS-1:0];
                n_step  = POS_W'(step_prod[39:16]);
                if (r_on[r_ch]) begin
                    n_state = ST_BYTE;
                end else if (r_ch == LAST_CH) begin
                    n_state = ST_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_BYTE: begin
                if (rdata == MARKER) begin
                    pos_we  = 1'b1;
                    n_a     = r_loop[r_ch];
                    rd_addr = n_a[RAM_ADDR_BITS-1:0];
                    n_state = ST_LOOP;
                end else begin
                    n_b     = rdata;
                    n_state = ST_GAIN;
                end
            end
            ST_LOOP: begin
                // marker again at the loop address: silent this tick
                if (rdata == MARKER) begin
                    if (r_ch == LAST_CH) begin
                        n_state = ST_DONE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_CHAN;
                    end
                end else begin
                    n_b     = rdata;
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                n_gl    = prod_l[11:5];
                n_gr    = prod_r[11:5];
                n_state = ST_MIX;
            end
            ST_MIX: begin
                if (r_b[7]) begin
                    n_acc_l = r_acc_l - SUM_W'(mix_l);
                    n_acc_r = r_acc_r - SUM_W'(mix_r);
                end else begin
                    n_acc_l = r_acc_l + SUM_W'(mix_l);
                    n_acc_r = r_acc_r + SUM_W'(mix_r);
                end
                pos_we  = 1'b1;
                pos_val = new_pos;
                n_k     = {1'b0, r_a} + 1'b1;
                n_a     = new_pos[POS_W-1:FRAC_BITS];
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // skipped bytes, one read per skipped byte
                if (r_k < {1'b0, r_a}) begin
                    rd_addr = r_k[RAM_ADDR_BITS-1:0];
                    n_state = ST_SCAN_CHK;
                end else begin
                    rd_addr = r_a[RAM_ADDR_BITS-1:0];
                    n_state = ST_FINAL;
                end
            end
            ST_SCAN_CHK: begin
                if (rdata == MARKER) begin
                    pos_we  = 1'b1;
                    n_a     = r_loop[r_ch];
                    rd_addr = n_a[RAM_ADDR_BITS-1:0];
                    n_state = ST_FINAL;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_FINAL: begin
                pos_we = (rdata == MARKER);
                if (r_ch == LAST_CH) begin
                    n_state = ST_DONE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = ST_CHAN;
                end
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_out_l = r_acc_l;
                n_out_r = r_acc_r;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_valid    <= 1'b0;
            r_sounding <= 1'b0;
            r_out_l    <= '0;
            r_out_r    <= '0;
            r_ch       <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_valid    <= n_valid;
            r_sounding <= n_sounding;
            r_out_l    <= n_out_l;
            r_out_r    <= n_out_r;
            r_ch       <= n_ch;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_k     <= n_k;
        r_b     <= n_b;
        r_gl    <= n_gl;
        r_gr    <= n_gr;
        r_step  <= n_step;
        r_acc_l <= n_acc_l;
        r_acc_r <= n_acc_r;
    end

    // channel and global registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_env[i]  <= '0;
                r_pan[i]  <= '0;
                r_base[i] <= '0;
                r_loop[i] <= '0;
                r_page[i] <= '0;
                r_pos[i]  <= '0;
            end
            r_on     <= '0;
            r_sel    <= '0;
            r_bank   <= '0;
            r_master <= 1'b0;
            r_rate   <= RATE_RESET;
        end else begin
            if (cfg_wr && !paddr[2]) begin
                r_rate <= pwdata[RATE_W-1:0];
            end
            if (pos_we) begin
                r_pos[r_ch] <= pos_val;
            end
            if (accept && (i_func == FN_REG)) begin
                unique case (i_reg_index)
                    RG_CONTROL: begin
                        if (i_value[6]) begin
                            r_sel <= i_value[2:0];
                        end else begin
                            r_bank <= i_value[3:0];
                        end
                        r_master <= i_value[7];
                    end
                    RG_CHAN_ON: begin
                        // channels off before the write restart at their start page
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (!r_on[i]) begin
                                r_pos[i] <= {r_page[i], {(FRAC_BITS + 8){1'b0}}};
                            end
                            r_on[i] <= !i_value[i];
                        end
                    end
                    RG_ENV:     if (sel_ok) r_env[sel_idx] <= i_value;
                    RG_PAN:     if (sel_ok) r_pan[sel_idx] <= i_value;
                    RG_STEP_LO: if (sel_ok) r_base[sel_idx][7:0] <= i_value;
                    RG_STEP_HI: if (sel_ok) r_base[sel_idx][15:8] <= i_value;
                    RG_LOOP_LO: if (sel_ok) r_loop[sel_idx][7:0] <= i_value;
                    RG_LOOP_HI: if (sel_ok) r_loop[sel_idx][15:8] <= i_value;
                    RG_START:   if (sel_ok) r_page[sel_idx] <= i_value;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- sv/pcmmix_checker.sv -----
// port-level checker of the pcm playback mixer, bound to the top level
// depends on: pcm_sample_playback_mixer_core_defines.svh, pcmmix_pkg, pcm_sample_playback_mixer_core
`timescale 1ns / 1ps
`include "pcm_sample_playback_mixer_core_defines.svh"

module pcmmix_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_func,
    input logic        o_valid,
    input logic [17:0] o_left_sum,
    input logic [17:0] o_right_sum,
    input logic        o_sounding
);

    import pcmmix_pkg::*;

    logic tick_req, other_req;
    assign tick_req  = start && !busy && (i_func == FN_TICK);
    assign other_req = start && !busy && (i_func != FN_TICK);

    // silent ticks carry zero sums
    `PCMMIX_ASSERT_NOW(a_silent_zero, o_valid && !o_sounding,
        (o_left_sum == 18'd0) && (o_right_sum == 18'd0), "nonzero sums while not sounding")
    // a tick request holds the block busy
    `PCMMIX_ASSERT_NEXT(a_tick_busy, tick_req, busy, "tick request did not raise busy")
    // requests other than ticks produce no result
    `PCMMIX_ASSERT_NEXT(a_write_silent, other_req, !o_valid, "result after a write request")
    // one strobe per tick
    `PCMMIX_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")

endmodule

bind pcm_sample_playback_mixer_core pcmmix_checker u_pcmmix_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_func      (i_func),
    .o_valid     (o_valid),
    .o_left_sum  (o_left_sum),
    .o_right_sum (o_right_sum),
    .o_sounding  (o_sounding)
);

// ----- tb/tb.sv -----
// self-checking testbench for pcm_sample_playback_mixer_core: random and directed requests,
// a predictor of every tick result, and apb writes of rate_scale between phases
// depends on: pcmmix_pkg, pcm_sample_playback_mixer_core
`timescale 1ns / 1ps

module tb;
    import pcmmix_pkg::*;

    typedef struct {
        t_func       fn;
        logic [3:0]  rg;
        logic [7:0]  val;
        logic [11:0] off;
    } t_req;

    typedef struct {
        logic [17:0] l;
        logic [17:0] r;
        logic        s;
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_func = '0;
    logic [3:0] i_reg_index = '0;
    logic [7:0] i_value = '0;
    logic [11:0] i_ram_offset = '0;
    logic o_valid;
    logic signed [SUM_W-1:0] o_left_sum, o_right_sum;
    logic o_sounding;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pcm_sample_playback_mixer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_func(i_func), .i_reg_index(i_reg_index), .i_value(i_value),
        .i_ram_offset(i_ram_offset),
        .o_valid(o_valid), .o_left_sum(o_left_sum), .o_right_sum(o_right_sum),
        .o_sounding(o_sounding),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mirror of the block state
    logic [7:0]  mem_m [0:65535];
    logic [7:0]  env_m [0:7];
    logic [7:0]  pan_m [0:7];
    logic [15:0] base_m [0:7];
    logic [26:0] step_m [0:7];
    logic [15:0] loop_m [0:7];
    logic [7:0]  page_m [0:7];
    logic [26:0] pos_m [0:7];
    logic        on_m [0:7];
    logic [2:0]  sel_m;
    logic [3:0]  bank_m;
    logic        master_m;
    logic [23:0] rate_m;

    t_req pending_reqs[$];
    t_mix expected_mixes[$];
    t_req cur_req;
    int   errors = 0;
    int   idle_pct = 22;
    int   gen_rate = 48260;
    bit   took = 1'b0;
    longint cycles = 0;

    task automatic report(input string what);
        errors++;
        $display("error at %0t: %s", $time, what);
    endtask

    function automatic void update_step(input int c);
        logic [47:0] p;
        p = 48'(base_m[c]) * 48'(rate_m);
        step_m[c] = p[42:16];
    endfunction

    // one enabled channel of a tick: read, loop on markers, mix, advance, scan skipped bytes
    function automatic void tick_channel(input int c, inout int l, inout int r);
        int unsigned a, k;
        logic [7:0] b;
        int gl, gr, mag;
        a = pos_m[c] >> FRAC_BITS;
        b = mem_m[a[15:0]];
        if (b == MARKER) begin
            pos_m[c] = {loop_m[c], 11'b0};
            a = loop_m[c];
            b = mem_m[a[15:0]];
        end
        if (b != MARKER) begin
            gl = (int'(env_m[c]) * int'(pan_m[c][3:0])) >>> 5;
            gr = (int'(env_m[c]) * int'(pan_m[c][7:4])) >>> 5;
            mag = int'(b[6:0]);
            if (b[7]) begin
                l -= mag * gl;
                r -= mag * gr;
            end else begin
                l += mag * gl;
                r += mag * gr;
            end
            k = a + 1;
            pos_m[c] = pos_m[c] + step_m[c];
            a = pos_m[c] >> FRAC_BITS;
            while (k < a) begin
                if (mem_m[k[15:0]] == MARKER) begin
                    pos_m[c] = {loop_m[c], 11'b0};
                    a = loop_m[c];
                    break;
                end
                k++;
            end
        end
        if (mem_m[a[15:0]] == MARKER) pos_m[c] = {loop_m[c], 11'b0};
    endfunction

    // apply one accepted request to the mirror and queue the tick result it causes
    function automatic void apply_request(input t_req q);
        int l, r, c;
        t_mix m;
        logic [7:0] d;
        l = 0;
        r = 0;
        c = sel_m;
        case (q.fn)
            FN_REG: begin
                if (q.rg == RG_CONTROL) begin
                    if (q.val[6]) sel_m = q.val[2:0];
                    else bank_m = q.val[3:0];
                    master_m = q.val[7];
                end else if (q.rg == RG_CHAN_ON) begin
                    d = ~q.val;
                    for (int i = 0; i < 8; i++) begin
                        if (!on_m[i]) pos_m[i] = {page_m[i], 19'b0};
                        on_m[i] = d[i];
                    end
                end else begin
                    case (q.rg)
                        RG_ENV:     env_m[c] = q.val;
                        RG_PAN:     pan_m[c] = q.val;
                        RG_STEP_LO: begin
                            base_m[c][7:0] = q.val;
                            update_step(c);
                        end
                        RG_STEP_HI: begin
                            base_m[c][15:8] = q.val;
                            update_step(c);
                        end
                        RG_LOOP_LO: loop_m[c][7:0] = q.val;
                        RG_LOOP_HI: loop_m[c][15:8] = q.val;
                        RG_START:   page_m[c] = q.val;
                        default: ; // unknown register index ignored
                    endcase
                end
            end
            FN_RAM: mem_m[{bank_m, q.off}] = q.val;
            FN_TICK: begin
                if (master_m)
                    for (int i = 0; i < 8; i++)
                        if (on_m[i]) tick_channel(i, l, r);
                m.l = l[17:0];
                m.r = r[17:0];
                m.s = master_m;
                expected_mixes.push_back(m);
            end
            default: ; // unused func ignored
        endcase
    endfunction

    // request acceptance and result check, both on the rising edge
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && start && !busy) begin
            apply_request(cur_req);
            took = 1'b1;
        end
        if (i_rst_n && o_valid) begin
            if (expected_mixes.size() == 0) begin
                report("tick result with nothing expected");
            end else begin
                t_mix e;
                e = expected_mixes.pop_front();
                if (o_left_sum !== e.l)
                    report($sformatf("left_sum %h, expected %h", o_left_sum, e.l));
                if (o_right_sum !== e.r)
                    report($sformatf("right_sum %h, expected %h", o_right_sum, e.r));
                if (o_sounding !== e.s)
                    report($sformatf("sounding %b, expected %b", o_sounding, e.s));
            end
        end
    end

    // request driver: fields change on the falling edge, start held until accepted
    always @(negedge i_clk) begin
        if (took || !start) begin
            took = 1'b0;
            if (i_rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cur_req = pending_reqs.pop_front();
                i_func <= cur_req.fn;
                i_reg_index <= cur_req.rg;
                i_value <= cur_req.val;
                i_ram_offset <= cur_req.off;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (cycles > 40000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_req(input int f, input int rg, input int v, input int o);
        t_req q;
        q.fn = t_func'(f[1:0]);
        q.rg = rg[3:0];
        q.val = v[7:0];
        q.off = o[11:0];
        pending_reqs.push_back(q);
    endtask

    // one random request, mostly well-formed channel setup and ticks
    task automatic push_random();
        int p, rg, v;
        p = $urandom_range(99);
        if (p < 40) begin
            push_req(FN_TICK, $urandom_range(15), $urandom_range(255), $urandom_range(4095));
        end else if (p < 60) begin
            v = ($urandom_range(9) == 0) ? 8'hFF : $urandom_range(255);
            push_req(FN_RAM, $urandom_range(15), v, $urandom_range(4095));
        end else if (p < 96) begin
            rg = $urandom_range(8);
            v = $urandom_range(255);
            if (rg == RG_CONTROL && $urandom_range(99) < 85) v[7] = 1'b1;
            if (rg == RG_STEP_HI && !(gen_rate <= 65536 && $urandom_range(9) == 0))
                v = $urandom_range(3);
            push_req(FN_REG, rg, v, $urandom_range(4095));
        end else if (p < 98) begin
            push_req(FN_NONE, $urandom_range(15), $urandom_range(255), $urandom_range(4095));
        end else begin
            push_req(FN_REG, $urandom_range(15, 9), $urandom_range(255), $urandom_range(4095));
        end
    endtask

    // hold off until every expected tick result has arrived and the block is quiet
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_mixes.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_rate(input int v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= '0;
        pwdata <= 32'(v[23:0]);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rate_m = v[23:0];
        for (int i = 0; i < 8; i++) update_step(i);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        int rates [5];
        for (int i = 0; i < 65536; i++) mem_m[i] = '0;
        for (int i = 0; i < 8; i++) begin
            env_m[i] = '0; pan_m[i] = '0; base_m[i] = '0; step_m[i] = '0;
            loop_m[i] = '0; page_m[i] = '0; pos_m[i] = '0; on_m[i] = 1'b0;
        end
        sel_m = '0;
        bank_m = '0;
        master_m = 1'b0;
        rate_m = RATE_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: master off tick, full gains, sign and marker bytes, unused codes
        push_req(FN_TICK, 0, 0, 0);
        push_req(FN_REG, RG_CONTROL, 8'hC0, 0);
        push_req(FN_REG, RG_ENV, 8'hFF, 0);
        push_req(FN_REG, RG_PAN, 8'hFF, 0);
        push_req(FN_REG, RG_STEP_LO, 8'hFF, 0);
        push_req(FN_REG, RG_STEP_HI, 8'h0F, 0);
        push_req(FN_REG, RG_LOOP_LO, 8'h01, 0);
        push_req(FN_REG, RG_LOOP_HI, 8'h00, 0);
        push_req(FN_REG, RG_CONTROL, 8'h80, 0);
        push_req(FN_RAM, 0, 8'h7F, 0);
        push_req(FN_RAM, 0, 8'hFF, 12'h003);
        push_req(FN_RAM, 0, 8'h81, 12'h001);
        push_req(FN_RAM, 0, 8'h55, 12'hFFF);
        push_req(FN_REG, RG_CHAN_ON, 8'hFE, 0);
        push_req(FN_TICK, 0, 0, 0);
        push_req(FN_TICK, 0, 0, 0);
        push_req(FN_REG, RG_CONTROL, 8'hC7, 0);
        push_req(FN_REG, RG_START, 8'hFF, 0);
        push_req(FN_REG, RG_ENV, 8'h80, 0);
        push_req(FN_REG, RG_PAN, 8'h1F, 0);
        push_req(FN_REG, RG_STEP_HI, 8'hFF, 0);
        push_req(FN_REG, RG_CHAN_ON, 8'h7E, 0);
        push_req(FN_TICK, 0, 0, 0);
        push_req(FN_NONE, 4'hF, 8'hFF, 12'hFFF);
        push_req(FN_REG, 4'hF, 8'hAA, 0);
        push_req(FN_TICK, 0, 0, 0);
        drain();

        rates[0] = 0;
        rates[1] = 24'hFFFFFF;
        rates[2] = $urandom_range(24'hFFFFFF);
        rates[3] = RATE_RESET;
        rates[4] = $urandom_range(65536, 1);
        for (int ph = 0; ph < 5; ph++) begin
            // wide steps are slow at high rates, so narrow every step first
            for (int c = 0; c < 8; c++) begin
                push_req(FN_REG, RG_CONTROL, 8'hC0 | c, 0);
                push_req(FN_REG, RG_STEP_HI, 0, 0);
            end
            drain();
            write_rate(rates[ph]);
            gen_rate = rates[ph];
            idle_pct = (ph % 3 == 0) ? 22 : (ph % 3 == 1) ? 49 : 0;
            for (int n = 0; n < 365; n++) push_random();
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/pcmmix_pkg.sv
sv/pcmmix_ram.sv
sv/pcm_sample_playback_mixer_core.sv
sv/pcmmix_checker.sv
tb/tb.sv
